/* src/tmie_pkg.sv */
// Shared opcodes, widths and command result type for the tape machine executor.
`default_nettype none

package tmie_pkg;

    localparam int unsigned CELL_W   = 8;
    localparam int unsigned INDEX_W  = 13;
    localparam int unsigned TARGET_W = 12;
    localparam int unsigned FUNC_W   = 3;

    typedef enum logic [FUNC_W-1:0] {
        OP_INC   = 3'd0,
        OP_DEC   = 3'd1,
        OP_LEFT  = 3'd2,
        OP_RIGHT = 3'd3,
        OP_OPEN  = 3'd4,
        OP_CLOSE = 3'd5,
        OP_PRINT = 3'd6,
        OP_INPUT = 3'd7
    } op_t;

    typedef struct packed {
        logic               cell_we;
        logic [CELL_W-1:0]  cell_new;
        logic               go_left;
        logic               go_right;
        logic [INDEX_W-1:0] next_index;
        logic               print_valid;
        logic [CELL_W-1:0]  print_byte;
        logic               done;
    } exec_res_t;

endpackage

`default_nettype wire

/* src/tmie_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module tmie_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32768
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* src/tmie_clear.sv */
// Post-reset sweep that walks every tape address once.
`default_nettype none

module tmie_clear #(
    parameter int unsigned TAPE_CELLS = 32768
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    output logic                               active,
    output logic [$clog2(TAPE_CELLS)-1:0]      addr
);

    localparam int unsigned AW = $clog2(TAPE_CELLS);
    localparam logic [AW-1:0] LAST = AW'(TAPE_CELLS - 1);

    logic          active_reg, active_next;
    logic [AW-1:0] addr_reg, addr_next;

    always_comb
    begin
        active_next = active_reg;
        addr_next   = addr_reg;
        if (active_reg)
        begin
            addr_next = addr_reg + AW'(1);
            if (addr_reg == LAST)
            begin
                active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b1;
            addr_reg   <= '0;
        end
        else
        begin
            active_reg <= active_next;
            addr_reg   <= addr_next;
        end
    end

    assign active = active_reg;
    assign addr   = addr_reg;

endmodule

`default_nettype wire

/* src/tmie_exec.sv */
// Command evaluation: cell update, pointer move request, next index and print.
`default_nettype none

module tmie_exec
    import tmie_pkg::*;
(
    input  wire logic [FUNC_W-1:0]   func,
    input  wire logic [TARGET_W-1:0] jump_target,
    input  wire logic [CELL_W-1:0]   input_byte,
    input  wire logic [CELL_W-1:0]   cell_val,
    input  wire logic [INDEX_W-1:0]  cmd_index,
    input  wire logic [INDEX_W-1:0]  prog_len,
    output exec_res_t                res
);

    logic               halted;
    logic [INDEX_W-1:0] jump_index;
    logic [INDEX_W-1:0] seq_index;
    logic               cell_zero;

    assign halted     = (cmd_index >= prog_len);
    assign jump_index = INDEX_W'(jump_target) + INDEX_W'(1);
    assign seq_index  = cmd_index + INDEX_W'(1);
    assign cell_zero  = (cell_val == '0);

    always_comb
    begin
        res             = '0;
        res.cell_new    = cell_val;
        res.next_index  = seq_index;
        case (op_t'(func))
            OP_INC:
            begin
                if (cell_val != '1)
                begin
                    res.cell_we  = 1'b1;
                    res.cell_new = cell_val + CELL_W'(1);
                end
            end
            OP_DEC:
            begin
                if (!cell_zero)
                begin
                    res.cell_we  = 1'b1;
                    res.cell_new = cell_val - CELL_W'(1);
                end
            end
            OP_LEFT:  res.go_left  = 1'b1;
            OP_RIGHT: res.go_right = 1'b1;
            OP_OPEN:
            begin
                if (cell_zero)
                begin
                    res.next_index = jump_index;
                end
            end
            OP_CLOSE:
            begin
                if (!cell_zero)
                begin
                    res.next_index = jump_index;
                end
            end
            OP_PRINT:
            begin
                res.print_valid = 1'b1;
                res.print_byte  = cell_val;
            end
            OP_INPUT:
            begin
                res.cell_we  = 1'b1;
                res.cell_new = input_byte;
            end
            default: res.next_index = seq_index;
        endcase
        res.done = (res.next_index >= prog_len);

        // past the end of the program: hold all state, report done
        if (halted)
        begin
            res            = '0;
            res.cell_new   = cell_val;
            res.next_index = cmd_index;
            res.done       = 1'b1;
        end
    end

endmodule

`default_nettype wire

/* src/tape_machine_instruction_executor_core.sv */
// Results are registered: a result is presented in the cycle after its command
// transfer. Throughput: one command per cycle while the output is not stalled,
// including pointer moves (the moved-to cell is read from the tape RAM in the
// cycle after the move and forwarded). Reset: asynchronous, active low;
// afterwards the tape is swept to zero, one cell per cycle over every address,
// with in_ready low meanwhile. Configuration writes are taken at any time.
`default_nettype none

module tape_machine_instruction_executor_core
    import tmie_pkg::*;
#(
    parameter int unsigned TAPE_CELLS    = 32768,
    parameter int unsigned PROGRAM_DEPTH = 4096
) (
    input  wire logic                clk,
    input  wire logic                rst_n,

    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [INDEX_W-1:0]  program_length,

    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [FUNC_W-1:0]   func,
    input  wire logic [TARGET_W-1:0] jump_target,
    input  wire logic [CELL_W-1:0]   input_byte,

    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [INDEX_W-1:0]       next_index,
    output logic                     print_valid,
    output logic [CELL_W-1:0]        print_byte,
    output logic                     done_res
);

    localparam int unsigned DP_W = $clog2(TAPE_CELLS);
    localparam logic [DP_W-1:0] DP_LAST = DP_W'(TAPE_CELLS - 1);

    logic               clearing;
    logic [DP_W-1:0]    clear_addr;

    logic [INDEX_W-1:0] len_reg;
    logic [INDEX_W-1:0] cmd_reg, cmd_next;
    logic [DP_W-1:0]    dp_reg, dp_next;
    logic [CELL_W-1:0]  cell_reg, cell_next;
    logic               fwd_reg, fwd_next;
    logic               out_valid_reg, out_valid_next;

    logic [INDEX_W-1:0] next_index_reg;
    logic               print_valid_reg;
    logic [CELL_W-1:0]  print_byte_reg;
    logic               done_reg;

    logic [CELL_W-1:0]  rd_data;
    logic [CELL_W-1:0]  cell_cur;
    logic               accept;
    logic               moved;
    logic               ram_we;
    logic [DP_W-1:0]    ram_wr_addr;
    logic [CELL_W-1:0]  ram_wr_data;
    exec_res_t          res;

    tmie_clear #(
        .TAPE_CELLS (TAPE_CELLS)
    ) u_clear (
        .clk    (clk),
        .rst_n  (rst_n),
        .active (clearing),
        .addr   (clear_addr)
    );

    tmie_ram #(
        .WIDTH (CELL_W),
        .DEPTH (TAPE_CELLS)
    ) u_tape (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (moved),
        .rd_addr (dp_next),
        .rd_data (rd_data)
    );

    // right after a move the current cell comes straight from the RAM
    assign cell_cur = fwd_reg ? rd_data : cell_reg;

    tmie_exec u_exec (
        .func        (func),
        .jump_target (jump_target),
        .input_byte  (input_byte),
        .cell_val    (cell_cur),
        .cmd_index   (cmd_reg),
        .prog_len    (len_reg),
        .res         (res)
    );

    assign cfg_ready = 1'b1;
    assign in_ready  = !clearing && (!out_valid_reg || out_ready);
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        dp_next = dp_reg;
        if (accept && res.go_left && (dp_reg != '0))
        begin
            dp_next = dp_reg - DP_W'(1);
        end
        else if (accept && res.go_right && (dp_reg != DP_LAST))
        begin
            dp_next = dp_reg + DP_W'(1);
        end
    end

    assign moved     = (dp_next != dp_reg);
    assign fwd_next  = moved;
    assign cell_next = (accept && res.cell_we) ? res.cell_new : cell_cur;
    assign cmd_next  = accept ? res.next_index : cmd_reg;

    assign ram_we      = clearing || (accept && res.cell_we);
    assign ram_wr_addr = clearing ? clear_addr : dp_reg;
    assign ram_wr_data = clearing ? '0 : res.cell_new;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            cmd_reg       <= '0;
            dp_reg        <= '0;
            cell_reg      <= '0;
            fwd_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                // saturate the length at the program capacity
                if (32'(program_length) > 32'(PROGRAM_DEPTH))
                begin
                    len_reg <= INDEX_W'(PROGRAM_DEPTH);
                end
                else
                begin
                    len_reg <= program_length;
                end
            end
            cmd_reg       <= cmd_next;
            dp_reg        <= dp_next;
            cell_reg      <= cell_next;
            fwd_reg       <= fwd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            next_index_reg  <= res.next_index;
            print_valid_reg <= res.print_valid;
            print_byte_reg  <= res.print_byte;
            done_reg        <= res.done;
        end
    end

    assign out_valid   = out_valid_reg;
    assign next_index  = next_index_reg;
    assign print_valid = print_valid_reg;
    assign print_byte  = print_byte_reg;
    assign done_res    = done_reg;

endmodule

`default_nettype wire
